// File: hdl/pmpe_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; every other file imports this package.
package pmpe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TDATA_W = 16;

    localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
    localparam logic [7:0] BTN_MASK      = 8'h07;

    // Position inside a packet
    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_X      = 2'd1;
    localparam logic [1:0] IDX_Y      = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_SYNC   = 2'd2;

    // Event codes
    localparam logic [1:0] CODE_LEFT   = 2'd0;
    localparam logic [1:0] CODE_RIGHT  = 2'd1;
    localparam logic [1:0] CODE_MIDDLE = 2'd2;
    localparam logic [1:0] CODE_X      = 2'd0;
    localparam logic [1:0] CODE_Y      = 2'd1;
    localparam logic [1:0] CODE_SYNC   = 2'd0;

    // Bits of the pending-event mask in the back end, in emit order
    localparam int unsigned EV_LEFT   = 0;
    localparam int unsigned EV_RIGHT  = 1;
    localparam int unsigned EV_MIDDLE = 2;
    localparam int unsigned EV_X      = 3;
    localparam int unsigned EV_Y      = 4;
    localparam int unsigned EV_SYNC   = 5;
    localparam int unsigned EV_N      = 6;

    // One decoded packet, passed from front end to back end
    typedef struct packed {
        logic [2:0]        buttons;
        logic [2:0]        changed;
        logic [BYTE_W-1:0] x_move;
        logic [BYTE_W-1:0] y_move;   // already negated
    } t_packet;

    // One output event
    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] value;
        logic [1:0]        code;
        logic [1:0]        kind;
    } t_event;

endpackage

// File: hdl/pmpe_front.sv
// Front end: aligns on header bytes, assembles three-byte packets and
// tracks button state. Depends on pmpe_pkg.
module pmpe_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_byte,
    output logic                    o_push,
    input  logic                    i_full,
    output pmpe_pkg::t_packet       o_packet
);
    import pmpe_pkg::*;

    logic [1:0] r_idx,     n_idx;
    logic [7:0] r_header,  n_header;
    logic [7:0] r_x,       n_x;
    logic [2:0] r_buttons, n_buttons;
    logic       w_accept;
    logic [2:0] w_btn;

    // Only the third byte needs queue space
    assign o_ready  = (r_idx != IDX_Y) || !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_btn    = r_header[2:0] & BTN_MASK[2:0];

    assign o_push           = w_accept && (r_idx == IDX_Y);
    assign o_packet.buttons = w_btn;
    assign o_packet.changed = w_btn ^ r_buttons;
    assign o_packet.x_move  = r_x;
    assign o_packet.y_move  = 8'd0 - i_byte;

    always_comb begin
        n_idx     = r_idx;
        n_header  = r_header;
        n_x       = r_x;
        n_buttons = r_buttons;
        if (w_accept) begin
            unique case (r_idx)
                IDX_X: begin
                    n_x   = i_byte;
                    n_idx = IDX_Y;
                end
                IDX_Y: begin
                    n_idx     = IDX_HEADER;
                    n_buttons = w_btn;
                end
                default: begin
                    // drop bytes that cannot start a packet
                    if ((i_byte & HDR_SYNC_MASK) != 8'd0) begin
                        n_header = i_byte;
                        n_idx    = IDX_X;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= IDX_HEADER;
            r_buttons <= 3'd0;
        end else begin
            r_idx     <= n_idx;
            r_buttons <= n_buttons;
        end
        r_header <= n_header;
        r_x      <= n_x;
    end

endmodule

// File: hdl/pmpe_queue.sv
// Two-entry packet queue between front and back ends.
// Depends on pmpe_pkg.
module pmpe_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  pmpe_pkg::t_packet       i_packet,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_empty,
    output pmpe_pkg::t_packet       o_packet
);
    import pmpe_pkg::*;

    t_packet    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full   = (r_count == 2'd2);
    assign o_empty  = (r_count == 2'd0);
    assign o_packet = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_packet;
        end
    end

endmodule

// File: hdl/pmpe_back.sv
// Back end: walks one packet's pending events in order and feeds a
// registered output stage. Depends on pmpe_pkg.
module pmpe_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  pmpe_pkg::t_packet       i_packet,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pmpe_pkg::t_event        o_event
);
    import pmpe_pkg::*;

    logic [EV_N-1:0] r_pend,  n_pend;
    logic [2:0]      r_btn;
    logic [7:0]      r_x, r_y;
    logic            r_ovalid;
    t_event          r_event, w_event;
    logic            w_load_out;
    logic            w_busy;
    logic [EV_N-1:0] w_pick;

    assign w_busy     = (r_pend != '0);
    assign w_load_out = !r_ovalid || i_ready;
    assign o_pop      = !w_busy && !i_empty;
    assign w_pick     = r_pend & (~r_pend + EV_N'(1));   // lowest pending event

    always_comb begin
        w_event = '0;
        case (1'b1)
            w_pick[EV_LEFT]: begin
                w_event.kind  = KIND_BUTTON;
                w_event.code  = CODE_LEFT;
                w_event.value = {7'd0, r_btn[0]};
            end
            w_pick[EV_RIGHT]: begin
                w_event.kind  = KIND_BUTTON;
                w_event.code  = CODE_RIGHT;
                w_event.value = {7'd0, r_btn[1]};
            end
            w_pick[EV_MIDDLE]: begin
                w_event.kind  = KIND_BUTTON;
                w_event.code  = CODE_MIDDLE;
                w_event.value = {7'd0, r_btn[2]};
            end
            w_pick[EV_X]: begin
                w_event.kind  = KIND_MOVE;
                w_event.code  = CODE_X;
                w_event.value = r_x;
            end
            w_pick[EV_Y]: begin
                w_event.kind  = KIND_MOVE;
                w_event.code  = CODE_Y;
                w_event.value = r_y;
            end
            default: begin
                w_event.kind = KIND_SYNC;
                w_event.code = CODE_SYNC;
                w_event.last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (o_pop) begin
            n_pend = {1'b1, (i_packet.y_move != 8'd0), (i_packet.x_move != 8'd0),
                      i_packet.changed};
        end else if (w_busy && w_load_out) begin
            n_pend = r_pend & ~w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_load_out) begin
                r_ovalid <= w_busy;
            end
        end
        if (o_pop) begin
            r_btn <= i_packet.buttons;
            r_x   <= i_packet.x_move;
            r_y   <= i_packet.y_move;
        end
        if (w_load_out && w_busy) begin
            r_event <= w_event;
        end
    end

    assign o_valid = r_ovalid;
    assign o_event = r_event;

endmodule

// File: hdl/ps2_mouse_packet_to_events.sv
// Top level of the PS/2 three-byte mouse packet decoder.
// Depends on pmpe_pkg, pmpe_front, pmpe_queue and pmpe_back.
//
//  channel   direction  payload
//  i_s_axis  in         tdata[7:0] rx_byte
//  o_m_axis  out        tdata[1:0] code, [9:2] value; tuser[1:0] kind; tlast last
//
// Bytes are taken one per cycle; only a third byte waits, when the
// two-entry packet queue is full. Each packet yields up to six events,
// one per cycle while the output is ready; the next packet is fetched
// only once all of them are issued. Reset (i_rst_n low, synchronous)
// clears the byte position, the button state and all valid flags.
// A stalled output holds its event while bytes keep flowing into the queue.
module ps2_mouse_packet_to_events (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] rx_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [pmpe_pkg::TDATA_W-1:0]   o_m_axis_tdata,  // [1:0] code, [9:2] value
    output logic [1:0]                     o_m_axis_tuser,  // [1:0] kind
    output logic                           o_m_axis_tlast   // last_of_packet
);
    import pmpe_pkg::*;

    logic    w_push, w_full, w_pop, w_empty;
    t_packet w_in_pkt, w_out_pkt;
    t_event  w_event;

    pmpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .o_push   (w_push),
        .i_full   (w_full),
        .o_packet (w_in_pkt)
    );

    pmpe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_in_pkt),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_empty  (w_empty),
        .o_packet (w_out_pkt)
    );

    pmpe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_packet (w_out_pkt),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_event  (w_event)
    );

    assign o_m_axis_tdata = TDATA_W'({w_event.value, w_event.code});
    assign o_m_axis_tuser = w_event.kind;
    assign o_m_axis_tlast = w_event.last;

endmodule
